FILE: sv/msk_pkg.sv
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Shared types and constants for the min-tracking stack and its cells.
// ----------------------------------------------------------------------------
package msk_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

FILE: sv/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// Min-tracking stack
// Bounded LIFO of signed values with a companion stack that tracks the minimum.
// ----------------------------------------------------------------------------
// Each request (push, pop or query) returns one result carrying the popped
// value, the current minimum (the largest positive value when empty), the
// entry count and a status. Both stacks are rows of shift cells whose top
// sits in the first cell, so every operation reads only the first two cells
// and the counters. The result is written into the output register at the
// same edge that accepts the request, so it can be taken in the next cycle.
// With the result side not stalling, one request is accepted every cycle;
// while a waiting result is stalled, the next request is held off. Popping
// an empty stack returns status empty and value 0; pushing onto a full stack
// is refused with status full.
module min_tracking_stack
    import msk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         request_valid,
    output logic                         request_stall,
    input  logic [1:0]                   operation,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] popped_value,
    output logic signed [DATA_WIDTH-1:0] current_min,
    output logic [CNT_W-1:0]             entry_count,
    output logic [1:0]                   status
);

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [CNT_W-1:0]      FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] val_cells [DEPTH];
    logic [DATA_WIDTH-1:0] min_cells [DEPTH];

    logic [CNT_W-1:0] value_count_reg, value_count_next;
    logic [CNT_W-1:0] min_count_reg, min_count_next;

    logic                  result_valid_reg;
    logic [DATA_WIDTH-1:0] popped_reg, popped_next;
    logic [DATA_WIDTH-1:0] cur_min_reg, cur_min_next;
    logic [CNT_W-1:0]      count_reg;
    status_t               status_reg, status_next;

    logic       accept;
    cell_ctrl_t val_ctrl, min_ctrl;

    assign request_stall = result_valid_reg && result_stall;
    assign accept        = request_valid && !request_stall;

    always_comb
    begin
        val_ctrl         = '0;
        min_ctrl         = '0;
        value_count_next = value_count_reg;
        min_count_next   = min_count_reg;
        popped_next      = '0;
        status_next      = ST_OK;
        case (operation)
            OP_PUSH:
            begin
                if (value_count_reg == FULL_CNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    val_ctrl.push    = accept;
                    value_count_next = value_count_reg + CNT_W'(1);
                    if ((min_count_reg == '0 ||
                         $signed(value) <= $signed(min_cells[0])) &&
                        min_count_reg != FULL_CNT)
                    begin
                        min_ctrl.push  = accept;
                        min_count_next = min_count_reg + CNT_W'(1);
                    end
                end
            end
            OP_POP:
            begin
                if (value_count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    val_ctrl.pop     = accept;
                    value_count_next = value_count_reg - CNT_W'(1);
                    popped_next      = val_cells[0];
                    if (min_count_reg != '0 && min_cells[0] == val_cells[0])
                    begin
                        min_ctrl.pop   = accept;
                        min_count_next = min_count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        if (min_count_next == '0)
        begin
            cur_min_next = MAX_POS;
        end
        else if (min_ctrl.push || (operation == OP_PUSH && min_count_next != min_count_reg))
        begin
            cur_min_next = value;
        end
        else if (min_count_next != min_count_reg)
        begin
            cur_min_next = min_cells[1];
        end
        else
        begin
            cur_min_next = min_cells[0];
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cells
            logic [DATA_WIDTH-1:0] val_upper, val_lower, min_upper, min_lower;
            if (i == 0)
            begin : g_top
                assign val_upper = value;
                assign min_upper = value;
            end
            else
            begin : g_mid
                assign val_upper = val_cells[i-1];
                assign min_upper = min_cells[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_bottom
                assign val_lower = '0;
                assign min_lower = '0;
            end
            else
            begin : g_inner
                assign val_lower = val_cells[i+1];
                assign min_lower = min_cells[i+1];
            end

            msk_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_val_cell (
                .clk        (clk),
                .ctrl       (val_ctrl),
                .upper_data (val_upper),
                .lower_data (val_lower),
                .data       (val_cells[i])
            );

            msk_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_min_cell (
                .clk        (clk),
                .ctrl       (min_ctrl),
                .upper_data (min_upper),
                .lower_data (min_lower),
                .data       (min_cells[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg  <= '0;
            min_count_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                value_count_reg  <= value_count_next;
                min_count_reg    <= min_count_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg  <= popped_next;
            cur_min_reg <= cur_min_next;
            count_reg   <= value_count_next;
            status_reg  <= status_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign popped_value = popped_reg;
    assign current_min  = cur_min_reg;
    assign entry_count  = count_reg;
    assign status       = status_reg;

endmodule

FILE: sv/msk_cell.sv
// ----------------------------------------------------------------------------
// Min-tracking stack cell
// One stack entry; shifts down from its upper neighbor on a push and up from
// its lower neighbor on a pop.
// ----------------------------------------------------------------------------
module msk_cell
    import msk_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] upper_data,
    input  logic [DATA_WIDTH-1:0] lower_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            data_reg <= upper_data;
        end
        else if (ctrl.pop)
        begin
            data_reg <= lower_data;
        end
    end

    assign data = data_reg;

endmodule

FILE: tb/sv/min_tracking_stack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack testbench
// Drives push, pop and query requests through the valid/stall handshake with
// random idling on both sides, keeps its own copy of both stacks to predict
// each result, and compares every returned result field by field.
// ----------------------------------------------------------------------------
module min_tracking_stack_test;
    import msk_pkg::*;

    localparam int DW         = DATA_WIDTH_DEF;
    localparam int STACK_SIZE = DEPTH_DEF;
    localparam int CNT_W      = $clog2(STACK_SIZE + 1);
    localparam int LONG_HOLD  = 120;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 10;

    localparam logic [1:0]           OP_SPARE  = 2'd3;
    localparam logic signed [DW-1:0] VALUE_MAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] VALUE_MIN = {1'b1, {(DW - 1){1'b0}}};

    typedef struct {
        logic signed [DW-1:0] popped;
        logic signed [DW-1:0] minimum;
        logic [CNT_W-1:0]     count;
        logic [1:0]           st;
    } stack_result_t;

    class min_stack_scoreboard;
        logic signed [DW-1:0] value_stack[$];
        logic signed [DW-1:0] min_stack[$];
        stack_result_t        expected_results[$];
        int errors;
        int pushes;
        int full_pushes;
        int pops;
        int empty_pops;
        int queries;
        int deepest;

        function int pending();
            return expected_results.size();
        endfunction

        function int depth();
            return value_stack.size();
        endfunction

        function void note_request(logic [1:0] op, logic signed [DW-1:0] v);
            stack_result_t r;
            r.popped = '0;
            r.st     = ST_OK;
            case (op)
                OP_PUSH:
                begin
                    pushes++;
                    if (value_stack.size() >= STACK_SIZE)
                    begin
                        r.st = ST_FULL;
                        full_pushes++;
                    end
                    else
                    begin
                        value_stack.push_back(v);
                        if (min_stack.size() == 0 || v <= min_stack[$])
                            min_stack.push_back(v);
                    end
                end
                OP_POP:
                begin
                    pops++;
                    if (value_stack.size() == 0)
                    begin
                        r.st = ST_EMPTY;
                        empty_pops++;
                    end
                    else
                    begin
                        r.popped = value_stack.pop_back();
                        if (min_stack.size() != 0 && min_stack[$] == r.popped)
                            void'(min_stack.pop_back());
                    end
                end
                default:
                    queries++;
            endcase
            r.minimum = (min_stack.size() == 0) ? VALUE_MAX : min_stack[$];
            r.count   = CNT_W'(value_stack.size());
            if (value_stack.size() > deepest)
                deepest = value_stack.size();
            expected_results.push_back(r);
        endfunction

        function void check_result(logic signed [DW-1:0] popped,
                                   logic signed [DW-1:0] minimum,
                                   logic [CNT_W-1:0] count, logic [1:0] st);
            stack_result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (popped !== e.popped)
            begin
                $display("%0t: popped_value expected %0d, got %0d", $time, e.popped, popped);
                errors++;
            end
            if (minimum !== e.minimum)
            begin
                $display("%0t: current_min expected %0d, got %0d", $time, e.minimum, minimum);
                errors++;
            end
            if (count !== e.count)
            begin
                $display("%0t: entry_count expected %0d, got %0d", $time, e.count, count);
                errors++;
            end
            if (st !== e.st)
            begin
                $display("%0t: status expected %0d, got %0d", $time, e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 request_valid;
    logic                 request_stall;
    logic [1:0]           operation;
    logic signed [DW-1:0] value;
    logic                 result_valid;
    logic                 result_stall;
    logic signed [DW-1:0] popped_value;
    logic signed [DW-1:0] current_min;
    logic [CNT_W-1:0]     entry_count;
    logic [1:0]           status;

    min_stack_scoreboard sb;
    bit hold_request;
    int idle_cycles;
    int result_count;

    min_tracking_stack dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .operation     (operation),
        .value         (value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .popped_value  (popped_value),
        .current_min   (current_min),
        .entry_count   (entry_count),
        .status        (status)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2, 3, 4, 5: return $signed(DW'($urandom_range(0, 20))) - 10;
            6: return $signed(DW'($urandom_range(0, 1))) - 1;
            default: return $signed(DW'($urandom));
        endcase
    endfunction

    function automatic logic [1:0] pick_operation(int push_pct, int pop_pct, int query_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return OP_PUSH;
        if (r < push_pct + pop_pct)
            return OP_POP;
        if (r < push_pct + pop_pct + query_pct)
            return OP_QUERY;
        return OP_SPARE;
    endfunction

    // Entered and left at a falling edge; the payload holds until accepted.
    task automatic send_request(input logic [1:0] op, input logic signed [DW-1:0] v,
                                input int gap);
        if (gap > 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_valid <= 1'b1;
        operation     <= op;
        value         <= v;
        do
            @(posedge clk);
        while (!(request_valid && !request_stall));
        @(negedge clk);
    endtask

    task automatic drive_result_stall();
        int stall_left;
        int cycle;
        stall_left = 0;
        cycle      = 0;
        forever
        begin
            @(negedge clk);
            cycle++;
            if (stall_left == 0)
            begin
                if (hold_request)
                begin
                    stall_left   = LONG_HOLD;
                    hold_request = 1'b0;
                end
                else if (cycle % 200 >= 100 && $urandom_range(0, 99) < 30)
                    stall_left = gap_len() + 1;
            end
            result_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_valid && !request_stall)
                sb.note_request(operation, value);
            if (result_valid && !result_stall)
            begin
                sb.check_result(popped_value, current_min, entry_count, status);
                result_count++;
            end
            if ((request_valid && !request_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("min_tracking_stack: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        request_valid = 1'b0;
        operation     = OP_PUSH;
        value         = '0;
        result_stall  = 1'b0;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        result_count  = 0;
        fork
            drive_result_stall();
        join_none
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty stack, ties on the minimum, extremes and the spare code.
        send_request(OP_POP, VALUE_MAX, gap_len());
        send_request(OP_QUERY, '0, gap_len());
        send_request(OP_SPARE, VALUE_MIN, gap_len());
        send_request(OP_PUSH, VALUE_MAX, gap_len());
        send_request(OP_PUSH, VALUE_MIN, gap_len());
        send_request(OP_PUSH, '0, gap_len());
        send_request(OP_PUSH, VALUE_MIN, gap_len());
        send_request(OP_PUSH, -1, gap_len());
        send_request(OP_QUERY, VALUE_MAX, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_QUERY, '0, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_PUSH, 5, gap_len());
        send_request(OP_PUSH, 5, gap_len());
        send_request(OP_PUSH, 7, gap_len());
        send_request(OP_SPARE, '0, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_POP, '0, gap_len());
        send_request(OP_POP, '0, gap_len());

        // Shallow mixed traffic that keeps running into the empty stack.
        for (int i = 0; i < 150; i++)
            send_request(pick_operation(40, 40, 15), pick_value(), gap_len());

        request_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);

        // Fill to the top while the result side holds off for a while.
        hold_request = 1'b1;
        for (int i = 0; sb.depth() < STACK_SIZE; i++)
            send_request(pick_operation(92, 4, 3), pick_value(),
                         ((i / 64) % 2 != 0) ? gap_len() : 0);
        for (int i = 0; i < 12; i++)
            send_request(pick_operation(80, 5, 10), pick_value(), gap_len());

        // Drain partway back down from the full stack.
        for (int i = 0; i < 130; i++)
            send_request(pick_operation(20, 70, 8), pick_value(), gap_len());

        request_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d pushes (%0d refused on full), %0d pops (%0d on empty),",
                 sb.pushes, sb.full_pushes, sb.pops, sb.empty_pops);
        $display("%0d queries and %0d checked results; deepest stack %0d entries.",
                 sb.queries, result_count, sb.deepest);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("min_tracking_stack: match");
        else
            $display("min_tracking_stack: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
sv/msk_pkg.sv
sv/msk_cell.sv
sv/min_tracking_stack.sv
tb/sv/min_tracking_stack_test.sv
